// ===== sv/rrts_pkg.sv =====
package rrts_pkg;

    // Default queue depth and reset value of the quantum register
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADMITTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_ZERO     = 3'd2,
        ST_PREEMPT  = 3'd3,
        ST_DONE     = 3'd4,
        ST_IDLE     = 3'd5
    } status_t;

    // Request kinds
    typedef enum logic {
        REQ_ADMIT = 1'b0,
        REQ_RUN   = 1'b1
    } req_t;

    // Engine sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // One queue slot
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] remaining;
    } slot_t;

    // One result word
    typedef struct packed {
        status_t     status;
        logic [7:0]  run_id;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } result_t;

endpackage

// ===== sv/rrts_queue_mem.sv =====
module rrts_queue_mem #(
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output rrts_pkg::slot_t       rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  rrts_pkg::slot_t       wr_data
);
    import rrts_pkg::*;

    slot_t mem [QUEUE_DEPTH];
    slot_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rrts_engine.sv =====
module rrts_engine #(
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request word
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [7:0]            proc_id,
    input  logic [15:0]           burst,
    input  logic [15:0]           quantum,
    // result toward the output register
    output logic                  res_valid,
    input  logic                  res_take,
    output rrts_pkg::result_t     res,
    // queue memory
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  rrts_pkg::slot_t       mem_rd_data,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output rrts_pkg::slot_t       mem_wr_data
);
    import rrts_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      now_reg, now_next;

    // latched request word
    logic             type_reg;
    logic [7:0]       id_reg;
    logic [15:0]      burst_reg;

    logic             accept;
    logic             fire;
    logic [15:0]      q_eff;
    logic [15:0]      rem;
    result_t          res_c;
    logic             wr_c;
    logic [15:0]      wr_rem_c;
    logic [7:0]       wr_id_c;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall  = 1'b1;
        res_valid = 1'b0;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_EXEC:  res_valid = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;
    assign fire   = res_valid && res_take;

    // Head slot is read as the word is taken
    assign mem_rd_en   = accept;
    assign mem_rd_addr = head_reg;

    // Evaluate the word against the head slot
    assign q_eff = (quantum == '0) ? 16'd1 : quantum;
    assign rem   = mem_rd_data.remaining;

    always_comb
    begin
        res_c.status     = ST_IDLE;
        res_c.run_id     = id_reg;
        res_c.start_time = now_reg;
        res_c.end_time   = now_reg;
        wr_c       = 1'b0;
        wr_id_c    = id_reg;
        wr_rem_c   = burst_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        now_next   = now_reg;
        if (type_reg == REQ_ADMIT)
        begin
            if (count_reg == FULL_CNT)
            begin
                res_c.status = ST_FULL;
            end
            else if (burst_reg == '0)
            begin
                res_c.status = ST_ZERO;
            end
            else
            begin
                res_c.status = ST_ADMITTED;
                wr_c         = 1'b1;
                tail_next    = next_idx(tail_reg);
                count_next   = count_reg + 1'b1;
            end
        end
        else if (count_reg == '0)
        begin
            res_c.run_id = '0;
        end
        else if (rem > q_eff)
        begin
            // slice used up: back to the tail with what is left
            res_c.status   = ST_PREEMPT;
            res_c.run_id   = mem_rd_data.id;
            now_next       = now_reg + {16'd0, q_eff};
            res_c.end_time = now_next;
            wr_c           = 1'b1;
            wr_id_c        = mem_rd_data.id;
            wr_rem_c       = rem - q_eff;
            head_next      = next_idx(head_reg);
            tail_next      = next_idx(tail_reg);
        end
        else
        begin
            res_c.status   = ST_DONE;
            res_c.run_id   = mem_rd_data.id;
            now_next       = now_reg + {16'd0, rem};
            res_c.end_time = now_next;
            head_next      = next_idx(head_reg);
            count_next     = count_reg - 1'b1;
        end
    end

    assign res                   = res_c;
    assign mem_wr_en             = fire && wr_c;
    assign mem_wr_addr           = tail_reg;
    assign mem_wr_data.id        = wr_id_c;
    assign mem_wr_data.remaining = wr_rem_c;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            now_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                now_reg   <= now_next;
            end
        end
    end

    // Request word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req_type;
            id_reg    <= proc_id;
            burst_reg <= burst;
        end
    end

    // Occupancy never exceeds the queue
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    // A preempted slot is requeued, occupancy unchanged
    a_preempt_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_c.status == ST_PREEMPT |=> $stable(count_reg))
        else $error("preempt changed occupancy");

    // A completed process leaves the queue
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_c.status == ST_DONE |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("completion did not free a slot");

    // Queue memory is written only as a result is handed on
    a_wr_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> state_reg == S_EXEC && res_take)
        else $error("queue write outside result hand-off");

endmodule

// ===== sv/round_robin_time_slice_scheduler_top.sv =====
// Round-robin time-slice scheduler. Each request word either admits a process
// (id and burst) at the tail of a queue of QUEUE_DEPTH slots, or runs the head
// process for at most one quantum; a preempted process goes back to the tail
// and a finished one leaves. Every request word gives exactly one result word
// with status, id and the start and end of the slice on a wrapping 32-bit time
// base. In the engine, state S_IDLE takes a word and reads the head slot from
// the queue memory (registered read), and S_EXEC evaluates and writes back;
// no new word is taken until the last result has gone on. The result sits in
// an output register, so the next request word is taken while a result still
// waits on out_stall. No clearing pass is needed after reset. The quantum
// register (reset 2, zero acts as one) is written through cfg_valid/cfg_ready
// only while no request is in flight: a user rule, not enforced by the block.
module round_robin_time_slice_scheduler_top #(
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] quantum,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  proc_id,
    input  logic [15:0] burst,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  run_id,
    output logic [31:0] start_time,
    output logic [31:0] end_time
);
    import rrts_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]      quantum_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;

    logic             res_valid;
    logic             res_take;
    result_t          res;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    slot_t            mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_t            mem_wr_data;

    // Quantum register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= quantum;
        end
    end

    rrts_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .proc_id     (proc_id),
        .burst       (burst),
        .quantum     (quantum_reg),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    rrts_queue_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_queue_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign run_id     = out_res_reg.run_id;
    assign start_time = out_res_reg.start_time;
    assign end_time   = out_res_reg.end_time;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rrts_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 78;

    // One request word as queued for the driver
    typedef struct {
        req_t        kind;
        logic [7:0]  pid;
        logic [15:0] len;
    } job_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] quantum = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [7:0]  proc_id = '0;
    logic [15:0] burst = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  run_id;
    logic [31:0] start_time;
    logic [31:0] end_time;

    // Scheduler mirror: queue slots, pointers, time base, quantum
    logic [7:0]  slot_pid [DEPTH];
    logic [15:0] slot_left [DEPTH];
    int          q_head = 0;
    int          q_tail = 0;
    int          q_count = 0;
    logic [31:0] sched_now = '0;
    logic [15:0] quantum_mirror = QUANTUM_RESET;

    job_t        job_backlog[$];
    result_t     due_results[$];
    job_t        cur_job;
    result_t     oldest_due;
    int          send_gap = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    bit          idle_on = 1'b1;

    round_robin_time_slice_scheduler_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .quantum    (quantum),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .proc_id    (proc_id),
        .burst      (burst),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .run_id     (run_id),
        .start_time (start_time),
        .end_time   (end_time)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one request word; updates the mirror
    function automatic result_t serve_job(job_t j);
        result_t     res;
        logic [15:0] slice;
        logic [15:0] left;
        res.status = ST_IDLE;
        res.run_id = j.pid;
        res.start_time = sched_now;
        res.end_time = sched_now;
        if (j.kind == REQ_ADMIT)
        begin
            if (q_count >= DEPTH)
                res.status = ST_FULL;
            else if (j.len == 16'd0)
                res.status = ST_ZERO;
            else
            begin
                slot_pid[q_tail] = j.pid;
                slot_left[q_tail] = j.len;
                q_tail = (q_tail + 1) % DEPTH;
                q_count++;
                res.status = ST_ADMITTED;
            end
        end
        else if (q_count == 0)
        begin
            res.run_id = '0;
        end
        else
        begin
            // zero quantum behaves as one
            slice = (quantum_mirror == 16'd0) ? 16'd1 : quantum_mirror;
            left = slot_left[q_head];
            res.run_id = slot_pid[q_head];
            q_head = (q_head + 1) % DEPTH;
            if (left > slice)
            begin
                // head is read before the tail write, so a full queue keeps order
                sched_now = sched_now + slice;
                slot_pid[q_tail] = res.run_id;
                slot_left[q_tail] = left - slice;
                q_tail = (q_tail + 1) % DEPTH;
                res.status = ST_PREEMPT;
            end
            else
            begin
                sched_now = sched_now + left;
                q_count--;
                res.status = ST_DONE;
            end
            res.end_time = sched_now;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic add_job(input req_t kind, input logic [7:0] pid, input logic [15:0] len);
        job_t j;
        j.kind = kind;
        j.pid = pid;
        j.len = len;
        job_backlog.push_back(j);
    endtask

    // Mostly short bursts so preemption is common, some zero and full-range
    function automatic logic [15:0] pick_burst();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 24));
    endfunction

    // Quantum write through the config channel; only called while idle
    task automatic write_quantum(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        quantum <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        quantum_mirror = value;
    endtask

    // Wait until every queued word went in and every result came back
    task automatic wait_drained();
        while (job_backlog.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random mix: single words, admit runs that may hit a full queue, run streaks
    task automatic random_phase(input int n_items);
        int made;
        int pick;
        int n;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                add_job(req_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_burst());
                made++;
            end
            else if (pick < 8)
            begin
                n = $urandom_range(12, 20);
                repeat (n) add_job(REQ_ADMIT, 8'($urandom_range(0, 255)), pick_burst());
                made += n;
            end
            else
            begin
                n = $urandom_range(6, 12);
                repeat (n) add_job(REQ_RUN, 8'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 65535)));
                made += n;
            end
        end
    endtask

    // Request driver: next word from the backlog, random gaps while idling is on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(serve_job(cur_job));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else if (job_backlog.size() > 0)
                begin
                    cur_job = job_backlog.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_job.kind;
                    proc_id <= cur_job.pid;
                    burst <= cur_job.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("result word with none pending, status %0d id %0d",
                                              status, run_id));
                else
                begin
                    oldest_due = due_results.pop_front();
                    if (status !== oldest_due.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest_due.status));
                    if (run_id !== oldest_due.run_id)
                        report_mismatch($sformatf("run_id %0d, expected %0d",
                                                  run_id, oldest_due.run_id));
                    if (start_time !== oldest_due.start_time)
                        report_mismatch($sformatf("start_time %0h, expected %0h",
                                                  start_time, oldest_due.start_time));
                    if (end_time !== oldest_due.end_time)
                        report_mismatch($sformatf("end_time %0h, expected %0h",
                                                  end_time, oldest_due.end_time));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset quantum of 2: empty run, zero burst, extremes
        add_job(REQ_RUN, 8'h3C, 16'hFFFF);
        add_job(REQ_ADMIT, 8'h00, 16'h0000);
        add_job(REQ_ADMIT, 8'hFF, 16'hFFFF);
        add_job(REQ_ADMIT, 8'hA5, 16'h0001);
        add_job(REQ_ADMIT, 8'h5A, 16'h0003);
        repeat (3) add_job(REQ_RUN, 8'h00, 16'h0000);
        // fill to the brim, then reject and preempt with a full queue
        for (i = 0; i < 14; i++)
            add_job(REQ_ADMIT, 8'(8'h10 + i), 16'(i + 1));
        add_job(REQ_ADMIT, 8'h77, 16'h0005);
        add_job(REQ_RUN, 8'hC3, 16'h1234);
        add_job(REQ_ADMIT, 8'h88, 16'h0009);
        wait_drained();

        // Zero quantum acts as one
        write_quantum(16'h0000);
        repeat (4) add_job(REQ_RUN, 8'h00, 16'h0000);
        wait_drained();

        // Largest quantum: empty the queue, then full-length slices back to back
        idle_on = 1'b0;
        write_quantum(16'hFFFF);
        repeat (20) add_job(REQ_RUN, 8'h00, 16'h0000);
        for (i = 0; i < 8; i++)
        begin
            add_job(REQ_ADMIT, 8'(i), 16'hFFFF);
            add_job(REQ_RUN, 8'(i), 16'h0000);
        end
        wait_drained();

        // Random phases over a spread of quanta
        idle_on = 1'b1;
        write_quantum(16'd1);
        random_phase(PHASE_ITEMS);
        wait_drained();
        write_quantum(16'd3);
        random_phase(PHASE_ITEMS);
        wait_drained();
        write_quantum(16'($urandom_range(1, 65535)));
        random_phase(PHASE_ITEMS);
        wait_drained();
        write_quantum(16'hFFFF);
        random_phase(PHASE_ITEMS);
        wait_drained();
        write_quantum(16'd7);
        random_phase(PHASE_ITEMS);
        wait_drained();
        write_quantum(16'($urandom_range(8, 40)));
        random_phase(PHASE_ITEMS);
        wait_drained();

        // Last part runs without idling on either side
        idle_on = 1'b0;
        write_quantum(16'($urandom_range(2, 6)));
        random_phase(PHASE_ITEMS);
        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rrts_pkg.sv
sv/rrts_queue_mem.sv
sv/rrts_engine.sv
sv/round_robin_time_slice_scheduler_top.sv
verif/tb.sv
